FILE: hdl/gta_pkg.sv
// Shared types and constants for the greedy tile assignment block.
`timescale 1ns / 1ps

package gta_pkg;

   // Sizes of the fields and of the used-tile store
   localparam int TILE_COUNT  = 2048;
   localparam int TILE_BITS   = $clog2(TILE_COUNT);
   localparam int SLOT_BITS   = 11;
   localparam int ORIENT_BITS = 3;
   localparam int SCORE_BITS  = 20;

   // Used-tile marks are run tags; tag zero means never marked
   localparam int EPOCH_BITS = 4;
   localparam logic [EPOCH_BITS-1:0] EPOCH_CLEAR = '0;
   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
   localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

   // Mode register codes
   localparam logic MODE_PLAIN  = 1'b0;
   localparam logic MODE_GREEDY = 1'b1;

   typedef struct packed {
      logic                   new_run;
      logic [SLOT_BITS-1:0]   target_index;
      logic [TILE_BITS-1:0]   tile;
      logic [ORIENT_BITS-1:0] orientation;
      logic [SCORE_BITS-1:0]  score;
      logic                   last_in_row;
   } req_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]   slot;
      logic [TILE_BITS-1:0]   chosen_tile;
      logic [ORIENT_BITS-1:0] chosen_orientation;
      logic [SCORE_BITS-1:0]  best_score;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic sweep;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic sweep_done;
      logic wrap_needed;
      logic commit_ok;
   } sts_type;

   typedef enum logic [2:0] {
      ST_SWEEP = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EVAL  = 3'b100
   } state_type;

endpackage

FILE: hdl/gta_req_if.sv
// Request channel: valid/ready handshake with one candidate per request.
`timescale 1ns / 1ps

interface gta_req_if;
   import gta_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/gta_rsp_if.sv
// Response channel: valid/ready handshake with one decided slot per response.
`timescale 1ns / 1ps

interface gta_rsp_if;
   import gta_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/greedy_tile_assignment_core.sv
// Greedy tile assignment: per-row minimum-score choice with a used-tile set.
//
// Requests arrive on req_chan, one candidate (tile, orientation, score) each,
// grouped into rows; last_in_row closes a row. The first candidate of a row
// is taken as is, later ones replace it on a strictly lower score and, in
// greedy mode, only if their tile is not yet used. Ties keep the earlier one.
// Closing a row puts one response on rsp_chan; in greedy mode the chosen tile
// is then marked used. new_run empties the used set before its request.
// csr_wr_en/csr_wr_data write the mode bit (1 greedy, 0 plain minimum).
// Each request is handled in two steps: the capture reads the tile's run tag
// from the 2048-entry tag memory, then the evaluation compares and commits. A
// response is valid in the cycle after the commit.
// The 15th new_run after reset, and every 14th one after that, holds its
// request for a wipe of all 2048 tags, then a fresh compare. After reset the
// block clears the whole tag memory with req_chan.ready low; mode returns
// to greedy. A response waits in its register while rsp_chan.ready is low;
// the next request is still accepted, and only a request that closes a row
// holds until the response is taken.
`timescale 1ns / 1ps

module greedy_tile_assignment_core (
   input  logic      clock,
   input  logic      reset,
   gta_req_if.sink   req_chan,
   gta_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);
   import gta_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gta_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_chan.data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_chan    (rsp_chan)
   );

endmodule

FILE: hdl/gta_ctrl.sv
// Controller: sequences tag sweeps, request capture and commit.
`timescale 1ns / 1ps

module gta_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gta_pkg::sts_type sts,
   output gta_pkg::cmd_type cmd
);
   import gta_pkg::*;

   state_type state_ff, state_in;
   logic      resume_ff, resume_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_done) begin
               state_in  = resume_ff ? ST_EVAL : ST_IDLE;
               resume_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // tag space exhausted: wipe the store, then finish this request
            if (sts.wrap_needed) begin
               state_in  = ST_SWEEP;
               resume_in = 1'b1;
            end else if (sts.commit_ok) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in  = ST_SWEEP;
            resume_in = 1'b0;
         end
      endcase
   end

   // State registers; reset starts with a full clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_SWEEP;
         resume_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
      end
   end

   a_capture_to_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_EVAL)
      else $error("capture did not lead to evaluation");

   a_commit_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> state_ff == ST_IDLE)
      else $error("commit did not return to idle");

endmodule

FILE: hdl/gta_datapath.sv
// Datapath: used-tile tag store, running best, mode and response register.
`timescale 1ns / 1ps

module gta_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  gta_pkg::req_type req_data,
   input  gta_pkg::cmd_type cmd,
   output gta_pkg::sts_type sts,
   gta_rsp_if.source        rsp_chan
);
   import gta_pkg::*;

   // Tag store: an entry counts as used when it holds the current run tag
   logic [EPOCH_BITS-1:0] tag_mem [TILE_COUNT];
   logic [EPOCH_BITS-1:0] rd_tag_ff;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [TILE_BITS-1:0]  sweep_cnt_ff;

   req_type               item_ff;
   logic                  mode_ff;
   logic                  row_open_ff;
   logic [SCORE_BITS-1:0] run_score_ff;
   logic [TILE_BITS-1:0]  run_tile_ff;
   logic [ORIENT_BITS-1:0] run_orient_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic                  used;
   logic                  take;
   logic [SCORE_BITS-1:0] best_score;
   logic [TILE_BITS-1:0]  best_tile;
   logic [ORIENT_BITS-1:0] best_orient;
   logic                  mem_we;
   logic [TILE_BITS-1:0]  mem_addr;
   logic [EPOCH_BITS-1:0] mem_wdata;

   // Candidate selection; a new run empties the used set before this request
   always_comb begin
      used        = (rd_tag_ff == epoch_ff) && !item_ff.new_run;
      take        = !row_open_ff ||
                    ((item_ff.score < run_score_ff) && ((mode_ff == MODE_PLAIN) || !used));
      best_score  = take ? item_ff.score       : run_score_ff;
      best_tile   = take ? item_ff.tile        : run_tile_ff;
      best_orient = take ? item_ff.orientation : run_orient_ff;
      epoch_in    = item_ff.new_run ? epoch_ff + EPOCH_FIRST : epoch_ff;
   end

   // Tag store write port: sweep clears, a greedy-mode commit that closes a row marks the chosen tile
   always_comb begin
      mem_we    = cmd.sweep ||
                  (cmd.commit && item_ff.last_in_row && (mode_ff == MODE_GREEDY));
      mem_addr  = cmd.sweep ? sweep_cnt_ff : best_tile;
      mem_wdata = cmd.sweep ? EPOCH_CLEAR : epoch_in;
   end

   always_comb begin
      sts.sweep_done  = (sweep_cnt_ff == TILE_BITS'(TILE_COUNT - 1));
      sts.wrap_needed = item_ff.new_run && (epoch_ff == EPOCH_LAST);
      sts.commit_ok   = !item_ff.last_in_row || !rsp_valid_ff || rsp_chan.ready;
   end

   // Tag store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_tag_ff <= tag_mem[req_data.tile];
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
   end

   // Sweep counter and run tag
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
         epoch_ff     <= EPOCH_FIRST;
      end else if (cmd.sweep) begin
         sweep_cnt_ff <= sweep_cnt_ff + TILE_BITS'(1);
         if (sts.sweep_done) begin
            epoch_ff <= EPOCH_FIRST;
         end
      end else if (cmd.commit) begin
         epoch_ff <= epoch_in;
      end
   end

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GREEDY;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // Running best of the open row
   always_ff @(posedge clock) begin
      if (reset) begin
         row_open_ff   <= 1'b0;
         run_score_ff  <= '0;
         run_tile_ff   <= '0;
         run_orient_ff <= '0;
      end else if (cmd.commit) begin
         row_open_ff   <= !item_ff.last_in_row;
         run_score_ff  <= best_score;
         run_tile_ff   <= best_tile;
         run_orient_ff <= best_orient;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && item_ff.last_in_row) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && item_ff.last_in_row) begin
         rsp_data_ff.slot               <= item_ff.target_index;
         rsp_data_ff.chosen_tile        <= best_tile;
         rsp_data_ff.chosen_orientation <= best_orient;
         rsp_data_ff.best_score         <= best_score;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && item_ff.last_in_row) |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("pending response overwritten");

   a_sweep_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> !(cmd.commit || cmd.capture))
      else $error("sweep overlaps request handling");

   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      !cmd.sweep |-> epoch_ff != EPOCH_CLEAR)
      else $error("run tag equals the cleared tag");

endmodule
